/* src/sps_pkg.sv */
`timescale 1ns / 1ps

package sps_pkg;

    localparam int MOTORS_DEF        = 4;
    localparam int COUNTER_WIDTH_DEF = 32;

    localparam int IDX_W       = 2;
    localparam int COUNT_W     = 16;
    localparam int PERIOD_W    = 32;
    localparam int OUT_MOTORS  = 4;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 16;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Per-motor strobes from the top level; at most one is set in a cycle.
    typedef struct packed {
        logic load;
        logic tick;
    } t_lane_ctl;

    // Per-motor view of the state after the current update.
    typedef struct packed {
        logic pulse;
        logic dir;
        logic busy;
    } t_lane_stat;

endpackage

/* src/sps_motor_lane.sv */
`timescale 1ns / 1ps

module sps_motor_lane #(
    parameter int COUNTER_WIDTH = sps_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sps_pkg::t_lane_ctl            i_ctl,
    input  logic [sps_pkg::COUNT_W-1:0]   i_step_count,
    input  logic [sps_pkg::PERIOD_W-1:0]  i_step_period,
    input  logic                          i_direction,
    output sps_pkg::t_lane_stat           o_stat
);

    logic [sps_pkg::COUNT_W-1:0]  r_rem,    n_rem;
    logic [COUNTER_WIDTH-1:0]     r_cnt,    n_cnt;
    logic [sps_pkg::PERIOD_W-1:0] r_period, n_period;
    logic                         r_dir,    n_dir;

    logic                     w_busy;
    logic [COUNTER_WIDTH-1:0] w_cnt_inc;
    logic                     w_match;
    logic                     w_step;

    always_comb begin
        w_busy    = (r_rem != '0);
        w_cnt_inc = r_cnt + 1'b1;
        // A period wider than the counter never matches; only the wrap fires then.
        w_match   = (sps_pkg::PERIOD_W'(w_cnt_inc) == r_period) || (w_cnt_inc == '0);
        w_step    = i_ctl.tick && w_busy && w_match;

        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_period = r_period;
        n_dir    = r_dir;

        if (i_ctl.load) begin
            n_rem    = i_step_count;
            n_period = i_step_period;
            n_dir    = i_direction;
            n_cnt    = '1;
        end else if (i_ctl.tick && w_busy) begin
            if (w_match) begin
                n_cnt = '0;
                n_rem = r_rem - 1'b1;
            end else begin
                n_cnt = w_cnt_inc;
            end
        end

        o_stat.pulse = w_step;
        o_stat.dir   = n_dir;
        o_stat.busy  = (n_rem != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem    <= '0;
            r_cnt    <= '1;
            r_period <= '0;
            r_dir    <= 1'b0;
        end else begin
            r_rem    <= n_rem;
            r_cnt    <= n_cnt;
            r_period <= n_period;
            r_dir    <= n_dir;
        end
    end

endmodule

/* src/multi_axis_step_pulse_scheduler.sv */
`timescale 1ns / 1ps

// Step pulse scheduler for several stepper motors.
// Slave channel: each word is either a load (tuser = 1), which gives the motor
// named in tdata a step count, a period in ticks and a direction, or a tick
// (tuser = 0), which advances every motor that still has steps to issue.
// Master channel: exactly one result word per input word, carrying the step
// pulses of that tick and the direction and busy bits of motors 0 to 3 after it.
// A word accepted from the slave channel is registered in the input register,
// processed by the motor lanes, and its result is registered in the output register.
// One word per cycle while results are taken; lanes compare and count in parallel.
// The input register keeps accepting while a finished result waits for the
// receiver; when both registers are full, tready drops until the result is taken.
// Reset clears all tasks: counters to all ones, steps, periods and directions
// to zero, and both registers empty.

module multi_axis_step_pulse_scheduler #(
    parameter int MOTORS        = sps_pkg::MOTORS_DEF,
    parameter int COUNTER_WIDTH = sps_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // motor_index[1:0], step_count[17:2], step_period[49:18], direction_in[50], zeros
    input  logic [sps_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // opcode[0]
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // step_pulses[3:0], direction_bits[7:4], busy_mask[11:8], zeros
    output logic [sps_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    localparam int OW = sps_pkg::OUT_MOTORS;

    logic                          r_in_valid, n_in_valid;
    logic                          r_in_op;
    logic [sps_pkg::IDX_W-1:0]     r_in_idx;
    logic [sps_pkg::COUNT_W-1:0]   r_in_count;
    logic [sps_pkg::PERIOD_W-1:0]  r_in_period;
    logic                          r_in_dir;

    logic                          r_out_valid, n_out_valid;
    logic [OW-1:0]                 r_out_pulses;
    logic [OW-1:0]                 r_out_dirs;
    logic [OW-1:0]                 r_out_busy;

    logic                          w_s_acc;
    logic                          w_adv;
    sps_pkg::t_lane_ctl            w_ctl  [MOTORS];
    sps_pkg::t_lane_stat           w_stat [MOTORS];
    logic [OW-1:0]                 w_pulses;
    logic [OW-1:0]                 w_dirs;
    logic [OW-1:0]                 w_busy;

    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_s_acc) begin
            n_in_valid = 1'b1;
        end else if (w_adv) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_adv) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_in_op     <= i_s_axis_tuser;
            r_in_idx    <= i_s_axis_tdata[1:0];
            r_in_count  <= i_s_axis_tdata[17:2];
            r_in_period <= i_s_axis_tdata[49:18];
            r_in_dir    <= i_s_axis_tdata[50];
        end
    end

    for (genvar m = 0; m < MOTORS; m++) begin : g_lane
        // A load naming a motor that is not present matches no lane.
        assign w_ctl[m].load = w_adv && (r_in_op == sps_pkg::OP_LOAD)
                               && (32'(r_in_idx) == m);
        assign w_ctl[m].tick = w_adv && (r_in_op == sps_pkg::OP_TICK);

        sps_motor_lane #(
            .COUNTER_WIDTH (COUNTER_WIDTH)
        ) u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl[m]),
            .i_step_count  (r_in_count),
            .i_step_period (r_in_period),
            .i_direction   (r_in_dir),
            .o_stat        (w_stat[m])
        );
    end

    for (genvar k = 0; k < OW; k++) begin : g_out
        if (k < MOTORS) begin : g_present
            assign w_pulses[k] = w_stat[k].pulse;
            assign w_dirs[k]   = w_stat[k].dir;
            assign w_busy[k]   = w_stat[k].busy;
        end else begin : g_absent
            assign w_pulses[k] = 1'b0;
            assign w_dirs[k]   = 1'b0;
            assign w_busy[k]   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_pulses <= w_pulses;
            r_out_dirs   <= w_dirs;
            r_out_busy   <= w_busy;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_busy, r_out_dirs, r_out_pulses};

    // A load never produces a step pulse.
    a_load_no_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_in_op == sps_pkg::OP_LOAD)) |=> (r_out_pulses == '0))
        else $error("step pulse reported for a load word");

    // A word waiting in the input register is not lost or altered.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_op)
                                    && $stable(r_in_period) && $stable(r_in_count)))
        else $error("input register changed while stalled");

    // A result that is not taken stays in the output register.
    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> r_out_valid)
        else $error("result dropped before it was taken");

endmodule
